// File: rtl/tpcf_pkg.sv
// Shared constants for the three point circle fit block.
// Field widths, status and register codes, saturation limits.
// No dependencies.
package tpcf_pkg;

  localparam int FieldBits  = 10;
  localparam int CenterBits = 20;
  localparam int RadiusBits = 16;
  localparam int RootSteps  = 17;
  localparam int RadBits    = 2 * RootSteps;
  localparam int RemBits    = RootSteps + 2;

  localparam int CenterMax  = 524287;
  localparam int CenterMin  = -524288;

  localparam logic [1:0] StatusAccept    = 2'd0;
  localparam logic [1:0] StatusReject    = 2'd1;
  localparam logic [1:0] StatusCollinear = 2'd2;

  localparam logic CfgMinRadius = 1'b0;
  localparam logic CfgMaxRadius = 1'b1;

  localparam logic [15:0] MinRadiusReset = 16'd320;
  localparam logic [15:0] MaxRadiusReset = 16'd640;
  localparam logic [15:0] RadiusMax      = 16'hFFFF;

endpackage

// File: rtl/three_point_circle_fit_top.sv
// Top level of the three point circle fit: circumcenter by pipelined
// long division, radius by pipelined digit-by-digit square root.
// Depends on tpcf_pkg.
//
// Usage: one beat on s_axis carries three points (six 10 bit fields, first_x
// in the lowest bits); one beat on m_axis returns the circle fit for it.
// Only the low COORD_BITS bits of each coordinate are used.
// Pipeline (CW = coordinate bits used): five setup stages, one divider stage
// per quotient bit (3*CW + 8), four center and distance stages, 17 square root
// stages and the output register.
// Throughput is one beat per cycle; every stage holds while m_axis stalls,
// and s_axis_tready drops only while a finished result waits.
// Configuration writes on cfg_we_i load min or max radius (Q4); write them
// only while the pipeline is empty. The squared limits are registered from the stored limits.
// Reset clears all valid bits and loads radius limits of 20.0 and 40.0 px.
module three_point_circle_fit_top #(
  parameter int COORD_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y (10 bits each)
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // center_x_q4 (20), center_y_q4 (20), radius_q4 (16), fit_status (2), saturated (1)
  output logic [63:0] m_axis_tdata
);

  localparam int FB   = tpcf_pkg::FieldBits;
  localparam int CW   = (COORD_BITS < FB) ? COORD_BITS : FB;
  localparam int PW   = 2 * CW + 2;
  localparam int SW   = 2 * CW + 1;
  localparam int NPW  = 3 * CW + 3;
  localparam int NSW  = 3 * CW + 5;
  localparam int NW   = 3 * CW + 8;
  localparam int DW   = 2 * CW + 2;
  localparam int RS   = tpcf_pkg::RootSteps;
  localparam int RB   = tpcf_pkg::RadBits;
  localparam int RMW  = tpcf_pkg::RemBits;
  localparam int CB   = tpcf_pkg::CenterBits;
  localparam int LAT  = 5 + NW + 4 + RS + 1;

  logic en;
  logic v_q [LAT];

  assign en            = !v_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  // configuration
  logic [15:0] min_q, max_q;
  logic [31:0] minsq_q, maxsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= tpcf_pkg::MinRadiusReset;
      max_q   <= tpcf_pkg::MaxRadiusReset;
      minsq_q <= 32'(tpcf_pkg::MinRadiusReset) * 32'(tpcf_pkg::MinRadiusReset);
      maxsq_q <= 32'(tpcf_pkg::MaxRadiusReset) * 32'(tpcf_pkg::MaxRadiusReset);
    end else begin
      minsq_q <= 32'(min_q) * 32'(min_q);
      maxsq_q <= 32'(max_q) * 32'(max_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tpcf_pkg::CfgMinRadius: min_q <= cfg_wdata_i;
          tpcf_pkg::CfgMaxRadius: max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // stage 1: capture points
  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= s_axis_tdata[0*FB +: CW];
      y1_q <= s_axis_tdata[1*FB +: CW];
      x2_q <= s_axis_tdata[2*FB +: CW];
      y2_q <= s_axis_tdata[3*FB +: CW];
      x3_q <= s_axis_tdata[4*FB +: CW];
      y3_q <= s_axis_tdata[5*FB +: CW];
    end
  end

  // stage 2: differences, determinant terms, squared norms
  logic signed [CW:0] d23, d31, d12, e32, e13, e21;
  assign d23 = $signed({1'b0, y2_q}) - $signed({1'b0, y3_q});
  assign d31 = $signed({1'b0, y3_q}) - $signed({1'b0, y1_q});
  assign d12 = $signed({1'b0, y1_q}) - $signed({1'b0, y2_q});
  assign e32 = $signed({1'b0, x3_q}) - $signed({1'b0, x2_q});
  assign e13 = $signed({1'b0, x1_q}) - $signed({1'b0, x3_q});
  assign e21 = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});

  logic signed [PW-1:0] pd1_q, pd2_q, pd3_q;
  logic [SW-1:0]        sq1_q, sq2_q, sq3_q;
  logic signed [CW:0]   d23_q, d31_q, d12_q, e32_q, e13_q, e21_q;
  logic [CW-1:0]        x1b_q, y1b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd1_q <= $signed({1'b0, x1_q}) * d23;
      pd2_q <= $signed({1'b0, x2_q}) * d31;
      pd3_q <= $signed({1'b0, x3_q}) * d12;
      sq1_q <= SW'(x1_q) * SW'(x1_q) + SW'(y1_q) * SW'(y1_q);
      sq2_q <= SW'(x2_q) * SW'(x2_q) + SW'(y2_q) * SW'(y2_q);
      sq3_q <= SW'(x3_q) * SW'(x3_q) + SW'(y3_q) * SW'(y3_q);
      d23_q <= d23; d31_q <= d31; d12_q <= d12;
      e32_q <= e32; e13_q <= e13; e21_q <= e21;
      x1b_q <= x1_q; y1b_q <= y1_q;
    end
  end

  // stage 3: determinant sum, numerator products
  logic signed [PW-1:0]  dt_q;
  logic signed [NPW-1:0] nxp1_q, nxp2_q, nxp3_q, nyp1_q, nyp2_q, nyp3_q;
  logic [CW-1:0]         x1c_q, y1c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dt_q   <= pd1_q + pd2_q + pd3_q;
      nxp1_q <= $signed({1'b0, sq1_q}) * d23_q;
      nxp2_q <= $signed({1'b0, sq2_q}) * d31_q;
      nxp3_q <= $signed({1'b0, sq3_q}) * d12_q;
      nyp1_q <= $signed({1'b0, sq1_q}) * e32_q;
      nyp2_q <= $signed({1'b0, sq2_q}) * e13_q;
      nyp3_q <= $signed({1'b0, sq3_q}) * e21_q;
      x1c_q  <= x1b_q; y1c_q <= y1b_q;
    end
  end

  // stage 4: numerator sums
  logic signed [NSW-1:0] nx_q, ny_q;
  logic signed [PW-1:0]  dd_q;
  logic [CW-1:0]         x1d_q, y1d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= NSW'(nxp1_q) + NSW'(nxp2_q) + NSW'(nxp3_q);
      ny_q  <= NSW'(nyp1_q) + NSW'(nyp2_q) + NSW'(nyp3_q);
      dd_q  <= dt_q;
      x1d_q <= x1c_q; y1d_q <= y1c_q;
    end
  end

  // stage 5: magnitudes and rounding offset, feed the dividers
  logic [NSW-1:0] anx, any;
  logic [PW-1:0]  ad;
  assign anx = nx_q[NSW-1] ? NSW'(-nx_q) : NSW'(nx_q);
  assign any = ny_q[NSW-1] ? NSW'(-ny_q) : NSW'(ny_q);
  assign ad  = dd_q[PW-1]  ? PW'(-dd_q)  : PW'(dd_q);

  logic [NW-1:0] qx_q [NW+1];
  logic [NW-1:0] qy_q [NW+1];
  logic [DW-1:0] rx_q [NW+1];
  logic [DW-1:0] ry_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [CW-1:0] dvx_q [NW+1];
  logic [CW-1:0] dvy_q [NW+1];
  logic          negx_q [NW+1];
  logic          negy_q [NW+1];
  logic          degd_q [NW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q[0]   <= NW'({anx, 4'b0000}) + NW'(ad);
      qy_q[0]   <= NW'({any, 4'b0000}) + NW'(ad);
      rx_q[0]   <= '0;
      ry_q[0]   <= '0;
      den_q[0]  <= DW'({ad, 1'b0});
      dvx_q[0]  <= x1d_q;
      dvy_q[0]  <= y1d_q;
      negx_q[0] <= nx_q[NSW-1] ^ dd_q[PW-1];
      negy_q[0] <= ny_q[NSW-1] ^ dd_q[PW-1];
      degd_q[0] <= (dd_q == '0);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW:0] tx, ty;
    logic        gx, gy;
    assign tx = {rx_q[k], qx_q[k][NW-1]};
    assign ty = {ry_q[k], qy_q[k][NW-1]};
    assign gx = tx >= {1'b0, den_q[k]};
    assign gy = ty >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k+1]   <= gx ? DW'(tx - {1'b0, den_q[k]}) : DW'(tx);
        ry_q[k+1]   <= gy ? DW'(ty - {1'b0, den_q[k]}) : DW'(ty);
        qx_q[k+1]   <= {qx_q[k][NW-2:0], gx};
        qy_q[k+1]   <= {qy_q[k][NW-2:0], gy};
        den_q[k+1]  <= den_q[k];
        dvx_q[k+1]  <= dvx_q[k];
        dvy_q[k+1]  <= dvy_q[k];
        negx_q[k+1] <= negx_q[k];
        negy_q[k+1] <= negy_q[k];
        degd_q[k+1] <= degd_q[k];
      end
    end
  end

  // stage A: signed center, clipping
  logic signed [NW:0] cx_s, cy_s;
  assign cx_s = negx_q[NW] ? -$signed({1'b0, qx_q[NW]}) : $signed({1'b0, qx_q[NW]});
  assign cy_s = negy_q[NW] ? -$signed({1'b0, qy_q[NW]}) : $signed({1'b0, qy_q[NW]});

  localparam logic signed [NW:0] CMax = (NW+1)'(tpcf_pkg::CenterMax);
  localparam logic signed [NW:0] CMin = (NW+1)'(tpcf_pkg::CenterMin);

  logic signed [NW:0] cxa_q, cya_q;
  logic [CB-1:0]      cxc_a_q, cyc_a_q;
  logic               sat_a_q, deg_a_q;
  logic [CW-1:0]      x1a_q, y1a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cxa_q   <= cx_s;
      cya_q   <= cy_s;
      cxc_a_q <= (cx_s > CMax) ? CB'(CMax) : (cx_s < CMin) ? CB'(CMin) : CB'(cx_s);
      cyc_a_q <= (cy_s > CMax) ? CB'(CMax) : (cy_s < CMin) ? CB'(CMin) : CB'(cy_s);
      sat_a_q <= (cx_s > CMax) || (cx_s < CMin) || (cy_s > CMax) || (cy_s < CMin);
      deg_a_q <= degd_q[NW];
      x1a_q   <= dvx_q[NW];
      y1a_q   <= dvy_q[NW];
    end
  end

  // stage A2: distance to the first point
  logic signed [NW+1:0] dx_s, dy_s;
  logic [NW+1:0]        adx, ady;
  assign dx_s = cxa_q - $signed({2'b00, x1a_q, 4'b0000});
  assign dy_s = cya_q - $signed({2'b00, y1a_q, 4'b0000});
  assign adx  = dx_s[NW+1] ? (NW+2)'(-dx_s) : (NW+2)'(dx_s);
  assign ady  = dy_s[NW+1] ? (NW+2)'(-dy_s) : (NW+2)'(dy_s);

  logic [15:0]   adx_q, ady_q;
  logic [CB-1:0] cxc_b_q, cyc_b_q;
  logic          sat_b_q, deg_b_q, big_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q   <= adx[15:0];
      ady_q   <= ady[15:0];
      big_b_q <= (|adx[NW+1:16]) || (|ady[NW+1:16]);
      cxc_b_q <= cxc_a_q; cyc_b_q <= cyc_a_q;
      sat_b_q <= sat_a_q; deg_b_q <= deg_a_q;
    end
  end

  // stage B: squares
  logic [31:0]   sqx_q, sqy_q;
  logic [CB-1:0] cxc_c_q, cyc_c_q;
  logic          sat_c_q, deg_c_q, big_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q   <= 32'(adx_q) * 32'(adx_q);
      sqy_q   <= 32'(ady_q) * 32'(ady_q);
      cxc_c_q <= cxc_b_q; cyc_c_q <= cyc_b_q;
      sat_c_q <= sat_b_q; deg_c_q <= deg_b_q; big_c_q <= big_b_q;
    end
  end

  // stage C: squared radius, feed the root
  logic [RB-1:0]  rad_q  [RS+1];
  logic [RMW-1:0] srem_q [RS+1];
  logic [RS-1:0]  root_q [RS+1];
  logic [CB-1:0]  rcx_q  [RS+1];
  logic [CB-1:0]  rcy_q  [RS+1];
  logic           rsat_q [RS+1];
  logic           rdeg_q [RS+1];
  logic           rbig_q [RS+1];
  logic           roor_q [RS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q[0]  <= RB'(sqx_q) + RB'(sqy_q);
      srem_q[0] <= '0;
      root_q[0] <= '0;
      rcx_q[0]  <= cxc_c_q; rcy_q[0] <= cyc_c_q;
      rsat_q[0] <= sat_c_q; rdeg_q[0] <= deg_c_q; rbig_q[0] <= big_c_q;
      roor_q[0] <= 1'b0;
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < RS; k++) begin : g_root
    logic [RMW+1:0] t, trial;
    logic           ge, cmp;
    assign t     = {srem_q[k], rad_q[k][RB-1:RB-2]};
    assign trial = (RMW+2)'({root_q[k], 2'b01});
    assign ge    = t >= trial;
    assign cmp   = (rad_q[k] < RB'(minsq_q)) || (rad_q[k] > RB'(maxsq_q));
    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[k+1] <= ge ? RMW'(t - trial) : RMW'(t);
        root_q[k+1] <= {root_q[k][RS-2:0], ge};
        rad_q[k+1]  <= {rad_q[k][RB-3:0], 2'b00};
        rcx_q[k+1]  <= rcx_q[k]; rcy_q[k+1] <= rcy_q[k];
        rsat_q[k+1] <= rsat_q[k]; rdeg_q[k+1] <= rdeg_q[k]; rbig_q[k+1] <= rbig_q[k];
        roor_q[k+1] <= (k == 0) ? cmp : roor_q[k];
      end
    end
  end

  // output register
  logic [15:0] radius;
  logic        rsat;
  logic [1:0]  status;
  assign rsat   = rbig_q[RS] || root_q[RS][RS-1];
  assign radius = rsat ? tpcf_pkg::RadiusMax : root_q[RS][15:0];
  assign status = (rbig_q[RS] || roor_q[RS]) ? tpcf_pkg::StatusReject
                                             : tpcf_pkg::StatusAccept;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rdeg_q[RS]) begin
        m_axis_tdata <= {5'b0, 1'b0, tpcf_pkg::StatusCollinear, 16'b0, 20'b0, 20'b0};
      end else begin
        m_axis_tdata <= {5'b0, rsat_q[RS] || rsat, status, radius, rcy_q[RS], rcx_q[RS]};
      end
    end
  end

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[57:56] != 2'd3))
    else $error("undefined fit status");

  a_collinear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[57:56] == tpcf_pkg::StatusCollinear)
      |-> (m_axis_tdata[55:0] == '0 && !m_axis_tdata[58]))
    else $error("collinear result carries data");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");

  a_sat_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[55:40] != 16'hFFFF
      && m_axis_tdata[57:56] == tpcf_pkg::StatusAccept)
      |-> (m_axis_tdata[55:40] >= min_q || min_q == 16'hFFFF))
    else $error("accepted radius below limit");

endmodule
